FILE: rtl/core/vfpf_pkg.sv
package vfpf_pkg;

   // Bitmap geometry
   localparam int BITMAP_CELLS = 1048576;
   localparam int KEY_W        = (BITMAP_CELLS > 1) ? $clog2(BITMAP_CELLS) : 1;
   localparam int ROW_BITS     = 32;
   localparam int ROW_SH       = $clog2(ROW_BITS);
   localparam int ROWS         = (BITMAP_CELLS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW       = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Field widths
   localparam int COORD_W   = 32;
   localparam int VSIZE_W   = 31;
   localparam int GRID_W    = 21;
   localparam int OUT_KEY_W = 20;
   localparam int COUNT_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DW    = 32;

   // Key arithmetic widths: |coord - origin| < 2^32, voxel index fits 34 bits signed,
   // ny + width*nz < 2^54 and the full key sum < 2^76 in magnitude.
   localparam int DIV_W  = 32;
   localparam int N_W    = 34;
   localparam int ACC_W  = 77;
   localparam int STEP_W = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z    = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOXEL_SIZE  = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_LENGTH = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 5;

   // Request commands
   localparam logic CMD_CLASSIFY = 1'b0;
   localparam logic CMD_CLEAR    = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic [VSIZE_W-1:0]        voxel_size;
      logic [GRID_W-1:0]         grid_length;
      logic [GRID_W-1:0]         grid_width;
   } cfg_type;

   typedef struct packed {
      logic             done;
      logic             out_of_range;
      logic [KEY_W-1:0] key;
   } kg_result_type;

   typedef enum logic [3:0] {
      KG_IDLE,
      KG_DIFF,
      KG_ABS,
      KG_DIV,
      KG_FIX,
      KG_MUL_W,
      KG_ADD_Y,
      KG_MUL_L,
      KG_ADD_X,
      KG_DONE
   } kg_state_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_KEY,
      ST_UPDATE,
      ST_EMIT
   } fpf_state_type;

endpackage

FILE: rtl/core/vfpf_ram.sv
module vfpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one row, read one row with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/vfpf_keygen.sv
module vfpf_keygen (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  vfpf_pkg::cfg_type                  cfg,
   input  logic signed [vfpf_pkg::COORD_W-1:0] coord_x,
   input  logic signed [vfpf_pkg::COORD_W-1:0] coord_y,
   input  logic signed [vfpf_pkg::COORD_W-1:0] coord_z,
   output vfpf_pkg::kg_result_type            result
);
   import vfpf_pkg::*;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [ACC_W-1:0] CELLS_ACC = ACC_W'(BITMAP_CELLS);

   kg_state_type       state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [GRID_W-1:0]  mul_ff, mul_in;
   logic [N_W-1:0]     nx_ff, nx_in;
   logic [N_W-1:0]     ny_ff, ny_in;

   logic [ACC_W-1:0]   add_a, add_b, add_sum;
   logic               add_sub, add_cin;
   logic signed [COORD_W-1:0] coord_sel, origin_sel;
   logic [VSIZE_W-1:0] divisor;
   logic               div_last, mul_last;

   // Shared adder/subtractor: every step of the key goes through it
   assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_cin);

   assign divisor  = (cfg.voxel_size == '0) ? VSIZE_W'(1) : cfg.voxel_size;
   assign div_last = (cnt_ff == STEP_W'(DIV_W - 1));
   assign mul_last = (cnt_ff == STEP_W'(GRID_W - 1));

   // Select the axis under work
   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            coord_sel  = coord_x;
            origin_sel = cfg.origin_x;
         end
         AXIS_Y: begin
            coord_sel  = coord_y;
            origin_sel = cfg.origin_y;
         end
         default: begin
            coord_sel  = coord_z;
            origin_sel = cfg.origin_z;
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         KG_IDLE:  if (start) state_in = KG_DIFF;
         KG_DIFF:  state_in = KG_ABS;
         KG_ABS:   state_in = KG_DIV;
         KG_DIV:   if (div_last) state_in = KG_FIX;
         KG_FIX:   state_in = (axis_ff == AXIS_Z) ? KG_MUL_W : KG_DIFF;
         KG_MUL_W: if (mul_last) state_in = KG_ADD_Y;
         KG_ADD_Y: state_in = KG_MUL_L;
         KG_MUL_L: if (mul_last) state_in = KG_ADD_X;
         KG_ADD_X: state_in = KG_DONE;
         KG_DONE:  state_in = KG_IDLE;
         default:  state_in = KG_IDLE;
      endcase
   end

   // Adder operands and datapath updates per step
   always_comb begin
      axis_in  = axis_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      mcand_in = mcand_ff;
      mul_in   = mul_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      add_a    = '0;
      add_b    = '0;
      add_sub  = 1'b0;
      add_cin  = 1'b0;
      case (state_ff)
         KG_IDLE: begin
            if (start) axis_in = AXIS_X;
         end
         // coord - origin, remember the sign
         KG_DIFF: begin
            add_a   = ACC_W'(coord_sel);
            add_b   = ACC_W'(origin_sel);
            add_sub = 1'b1;
            add_cin = 1'b1;
            acc_in  = add_sum;
            neg_in  = add_sum[ACC_W-1];
         end
         // take the magnitude as dividend
         KG_ABS: begin
            add_b   = acc_ff;
            add_sub = neg_ff;
            add_cin = neg_ff;
            quo_in  = add_sum[DIV_W-1:0];
            acc_in  = '0;
            cnt_in  = '0;
         end
         // restoring division, one quotient bit a step
         KG_DIV: begin
            add_a   = {acc_ff[ACC_W-2:0], quo_ff[DIV_W-1]};
            add_b   = ACC_W'(divisor);
            add_sub = 1'b1;
            add_cin = 1'b1;
            if (!add_sum[ACC_W-1]) begin
               acc_in = add_sum;
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               acc_in = add_a;
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + STEP_W'(1);
         end
         // round toward minus infinity: -(q + (r != 0)) for a negative dividend
         KG_FIX: begin
            add_a   = neg_ff ? ~ACC_W'(quo_ff) : ACC_W'(quo_ff);
            add_cin = neg_ff & (acc_ff == '0);
            case (axis_ff)
               AXIS_X: begin
                  nx_in   = add_sum[N_W-1:0];
                  axis_in = AXIS_Y;
               end
               AXIS_Y: begin
                  ny_in   = add_sum[N_W-1:0];
                  axis_in = AXIS_Z;
               end
               default: begin
                  mcand_in = add_sum;
                  acc_in   = '0;
                  mul_in   = cfg.grid_width;
                  cnt_in   = '0;
               end
            endcase
         end
         // shift-add multiply, multiplier bits taken from the top
         KG_MUL_W, KG_MUL_L: begin
            add_a  = {acc_ff[ACC_W-2:0], 1'b0};
            add_b  = mul_ff[GRID_W-1] ? mcand_ff : '0;
            acc_in = add_sum;
            mul_in = {mul_ff[GRID_W-2:0], 1'b0};
            cnt_in = cnt_ff + STEP_W'(1);
         end
         // ny + width*nz becomes the next multiplicand
         KG_ADD_Y: begin
            add_a    = acc_ff;
            add_b    = ACC_W'($signed(ny_ff));
            mcand_in = add_sum;
            acc_in   = '0;
            mul_in   = cfg.grid_length;
            cnt_in   = '0;
         end
         KG_ADD_X: begin
            add_a  = acc_ff;
            add_b  = ACC_W'($signed(nx_ff));
            acc_in = add_sum;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      axis_ff  <= axis_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      quo_ff   <= quo_in;
      mcand_ff <= mcand_in;
      mul_ff   <= mul_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
   end

   // Key and range flag are valid while done is high
   assign result.done         = (state_ff == KG_DONE);
   assign result.out_of_range = acc_ff[ACC_W-1] | (acc_ff >= CELLS_ACC);
   assign result.key          = KEY_W'(acc_ff);

endmodule

FILE: rtl/core/voxel_first_point_filter.sv
// Voxel grid first-point filter. Each request classifies one point (or clears the
// occupancy bitmap and the retained count) and returns exactly one response. For a
// point that needs a voxel key, the three per-axis floor divisions (difference,
// magnitude, 32 restoring steps, rounding) and the two 21-step shift-add multiplies
// of the key all run on one shared 77-bit adder, followed by a read-modify-write of
// one 32-bit bitmap row. Deleted or excluded points skip the key and go straight to
// the response. The bitmap is a single-port-write RAM of 32768 rows of 32 bits; after
// reset and on every clear request it is wiped one row per cycle, and no request is
// taken until the wipe is over. Registers may be written at any time while idle.
module voxel_first_point_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic signed [vfpf_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [vfpf_pkg::COORD_W-1:0]   req_coord_y,
   input  logic signed [vfpf_pkg::COORD_W-1:0]   req_coord_z,
   input  logic                                 req_excluded,
   input  logic                                 req_already_deleted,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_keep,
   output logic                                 rsp_new_voxel,
   output logic                                 rsp_out_of_range,
   output logic [vfpf_pkg::OUT_KEY_W-1:0]       rsp_voxel_key,
   output logic [vfpf_pkg::COUNT_W-1:0]         rsp_retained_count,
   input  logic                                 csr_write_en,
   input  logic [vfpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vfpf_pkg::CSR_DW-1:0]          csr_write_data
);
   import vfpf_pkg::*;

   fpf_state_type        state_ff, state_in;
   cfg_type              cfg_ff, cfg_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [ROW_AW-1:0]    clr_addr_ff, clr_addr_in;
   logic                 clr_cmd_ff, clr_cmd_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 res_keep_ff, res_keep_in;
   logic                 res_new_ff, res_new_in;
   logic                 res_oor_ff, res_oor_in;
   logic [KEY_W-1:0]     res_key_ff, res_key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_keep_ff, rsp_keep_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_oor_ff, rsp_oor_in;
   logic [OUT_KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 req_acc, out_free, clr_last, occupied;
   logic                 kg_start;
   kg_result_type        kg_res;
   logic                 ram_we, ram_re;
   logic [ROW_AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ROW_BITS-1:0]  ram_wr_data, ram_rd_data;
   logic [ROW_SH-1:0]    bit_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign clr_last  = (clr_addr_ff == ROW_AW'(ROWS - 1));
   assign bit_idx   = ROW_SH'(key_ff);
   assign occupied  = ram_rd_data[bit_idx];

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_write_data;
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_write_data;
            CSR_ORIGIN_Z:    cfg_in.origin_z    = csr_write_data;
            CSR_VOXEL_SIZE:  cfg_in.voxel_size  = csr_write_data[VSIZE_W-1:0];
            CSR_GRID_LENGTH: cfg_in.grid_length = csr_write_data[GRID_W-1:0];
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_write_data[GRID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = clr_cmd_ff ? ST_EMIT : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req_command == CMD_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_already_deleted || req_excluded) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_KEY;
               end
            end
         end
         ST_KEY: begin
            if (kg_res.done) state_in = kg_res.out_of_range ? ST_EMIT : ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, bitmap access and response
   always_comb begin
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      clr_addr_in  = clr_addr_ff;
      clr_cmd_in   = clr_cmd_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      res_keep_in  = res_keep_ff;
      res_new_in   = res_new_ff;
      res_oor_in   = res_oor_ff;
      res_key_in   = res_key_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_keep_in  = rsp_keep_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_count_in = rsp_count_ff;
      kg_start     = 1'b0;
      ram_we       = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = '0;
      ram_re       = 1'b0;
      ram_rd_addr  = ROW_AW'(kg_res.key >> ROW_SH);
      case (state_ff)
         // wipe one row per cycle
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_last ? '0 : clr_addr_ff + ROW_AW'(1);
         end
         ST_IDLE: begin
            if (req_acc) begin
               cx_in       = req_coord_x;
               cy_in       = req_coord_y;
               cz_in       = req_coord_z;
               res_keep_in = 1'b0;
               res_new_in  = 1'b0;
               res_oor_in  = 1'b0;
               res_key_in  = '0;
               if (req_command == CMD_CLEAR) begin
                  clr_cmd_in  = 1'b1;
                  clr_addr_in = '0;
                  count_in    = '0;
               end else if (req_already_deleted) begin
                  // drop: stays deleted
               end else if (req_excluded) begin
                  res_keep_in = 1'b1;
               end else begin
                  kg_start = 1'b1;
               end
            end
         end
         // key ready: out of range is kept without a bitmap access, else read the row
         ST_KEY: begin
            if (kg_res.done) begin
               key_in = kg_res.key;
               if (kg_res.out_of_range) begin
                  res_keep_in = 1'b1;
                  res_oor_in  = 1'b1;
               end else begin
                  ram_re = 1'b1;
               end
            end
         end
         // claim the voxel if its bit is still clear
         ST_UPDATE: begin
            res_key_in = key_ff;
            if (!occupied) begin
               ram_we      = 1'b1;
               ram_wr_addr = ROW_AW'(key_ff >> ROW_SH);
               ram_wr_data = ram_rd_data | (ROW_BITS'(1) << bit_idx);
               res_keep_in = 1'b1;
               res_new_in  = 1'b1;
               if (count_ff != '1) count_in = count_ff + COUNT_W'(1);
            end
         end
         // hand the result to the output register
         ST_EMIT: begin
            clr_cmd_in = 1'b0;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in  = res_keep_ff;
               rsp_new_in   = res_new_ff;
               rsp_oor_in   = res_oor_ff;
               rsp_key_in   = OUT_KEY_W'(res_key_ff);
               rsp_count_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_cmd_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.origin_z    <= '0;
         cfg_ff.voxel_size  <= VSIZE_W'(1);
         cfg_ff.grid_length <= GRID_W'(1);
         cfg_ff.grid_width  <= GRID_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_cmd_ff   <= clr_cmd_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      key_ff       <= key_in;
      res_keep_ff  <= res_keep_in;
      res_new_ff   <= res_new_in;
      res_oor_ff   <= res_oor_in;
      res_key_ff   <= res_key_in;
      rsp_keep_ff  <= rsp_keep_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_oor_ff   <= rsp_oor_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_count_ff <= rsp_count_in;
   end

   vfpf_keygen u_keygen (
      .clock   (clock),
      .reset   (reset),
      .start   (kg_start),
      .cfg     (cfg_ff),
      .coord_x (cx_ff),
      .coord_y (cy_ff),
      .coord_z (cz_ff),
      .result  (kg_res)
   );

   vfpf_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keep           = rsp_keep_ff;
   assign rsp_new_voxel      = rsp_new_ff;
   assign rsp_out_of_range   = rsp_oor_ff;
   assign rsp_voxel_key      = rsp_key_ff;
   assign rsp_retained_count = rsp_count_ff;

endmodule
